[sv/lpr_pkg.sv]
// shared types, constants and defaults for the lru page replacement core
package lpr_pkg;

  localparam int LPR_PAGE_W         = 16;
  localparam int LPR_FAULT_W        = 16;
  localparam int LPR_CFG_W          = 4;
  localparam int LPR_FRAMES_DEF     = 8;
  localparam int LPR_PAGE_BITS_DEF  = 16;

  localparam logic [LPR_CFG_W-1:0]   LPR_CFG_RESET = 4'd8;
  localparam logic [LPR_FAULT_W-1:0] LPR_FAULT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [LPR_PAGE_W-1:0] page_number;
    logic                  last_reference;
  } lpr_in_t;

  typedef struct packed {
    logic                   was_hit;
    logic                   did_evict;
    logic [LPR_PAGE_W-1:0]  evicted_page;
    logic [LPR_FAULT_W-1:0] fault_total;
    logic                   run_done;
  } lpr_out_t;

endpackage

[sv/lpr_in_stage.sv]
// input register holding the reference under lookup
module lpr_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lpr_pkg::lpr_in_t in_data,
  output logic             item_valid,
  output lpr_pkg::lpr_in_t item_data,
  input  logic             item_take
);

  logic             valid_r;
  logic             valid_nxt;
  lpr_pkg::lpr_in_t data_r;

  // a new beat can enter when the stage is empty or drains this cycle
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

[sv/lpr_frame_table.sv]
// frame tags, recency ranks, occupancy, fault counter and the lookup/update logic
module lpr_frame_table #(
  parameter int FRAMES    = lpr_pkg::LPR_FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::LPR_PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpr_pkg::LPR_CFG_W-1:0] cfg_data,
  input  logic                          step,
  input  lpr_pkg::lpr_in_t              item,
  output lpr_pkg::lpr_out_t             result
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int CMP_W  = (CNT_W > lpr_pkg::LPR_CFG_W) ? CNT_W : lpr_pkg::LPR_CFG_W;
  localparam int PW     = lpr_pkg::LPR_PAGE_W;
  localparam int FW     = lpr_pkg::LPR_FAULT_W;

  logic [lpr_pkg::LPR_CFG_W-1:0] cfg_r;
  logic [PAGE_BITS-1:0]          tag_r [FRAMES];
  logic [FRAMES-1:0]             valid_r;
  logic [FRAMES-1:0]             valid_nxt;
  logic [RANK_W-1:0]             rank_r [FRAMES];
  logic [RANK_W-1:0]             rank_nxt [FRAMES];
  logic [CNT_W-1:0]              occ_r;
  logic [CNT_W-1:0]              occ_nxt;
  logic [FW-1:0]                 fault_r;
  logic [FW-1:0]                 fault_nxt;

  logic [CMP_W-1:0]          cfg_ext;
  logic [CMP_W-1:0]          limit_ext;
  logic [CNT_W-1:0]          limit;
  logic [PW+PAGE_BITS-1:0]   page_ext;
  logic [PAGE_BITS-1:0]      page_tag;
  logic [FRAMES-1:0]         match;
  logic [FRAMES-1:0]         lru;
  logic [IDX_W-1:0]          hit_idx;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          lru_idx;
  logic [IDX_W-1:0]          sel_idx;
  logic [RANK_W-1:0]         hit_rank;
  logic                      hit;
  logic                      fill;
  logic                      evict;
  logic [PAGE_BITS+PW-1:0]   victim_ext;

  assign cfg_ready = 1'b1;

  // clamp the configured frame count into 1..FRAMES
  assign cfg_ext   = CMP_W'(cfg_r);
  assign limit_ext = (cfg_ext == '0) ? CMP_W'(1) :
                     (cfg_ext > CMP_W'(FRAMES)) ? CMP_W'(FRAMES) : cfg_ext;
  assign limit     = limit_ext[CNT_W-1:0];

  assign page_ext = {{PAGE_BITS{1'b0}}, item.page_number};
  assign page_tag = page_ext[PAGE_BITS-1:0];

  // valid ranks are always a permutation of 0..occ-1, so the oldest frame has rank occ-1
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == page_tag);
      lru[i]   = valid_r[i] && (CNT_W'(rank_r[i]) == (occ_r - CNT_W'(1)));
    end
  end

  // lowest-numbered frame wins in each search
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
      if (lru[i]) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  assign hit      = |match;
  assign fill     = !hit && (occ_r < limit);
  assign evict    = !hit && !fill;
  assign sel_idx  = hit ? hit_idx : (fill ? free_idx : lru_idx);
  assign hit_rank = rank_r[hit_idx];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (IDX_W'(i) == sel_idx) begin
        rank_nxt[i] = '0;
      end else if (valid_r[i] && (!hit || (rank_r[i] < hit_rank))) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
      valid_nxt[i] = valid_r[i] || (fill && (IDX_W'(i) == free_idx));
    end
  end

  assign occ_nxt   = fill ? (occ_r + CNT_W'(1)) : occ_r;
  assign fault_nxt = (!hit && (fault_r != lpr_pkg::LPR_FAULT_MAX)) ?
                     (fault_r + FW'(1)) : fault_r;

  assign victim_ext = {{PW{1'b0}}, tag_r[lru_idx]};

  always_comb begin
    result.was_hit      = hit;
    result.did_evict    = evict;
    result.evicted_page = evict ? victim_ext[PW-1:0] : '0;
    result.fault_total  = fault_nxt;
    result.run_done     = item.last_reference;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lpr_pkg::LPR_CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      fault_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (step) begin
      // end of run drops every frame and the count
      if (item.last_reference) begin
        valid_r <= '0;
        occ_r   <= '0;
        fault_r <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_r[i] <= '0;
        end
      end else begin
        valid_r <= valid_nxt;
        occ_r   <= occ_nxt;
        fault_r <= fault_nxt;
        for (int i = 0; i < FRAMES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !hit) begin
      tag_r[sel_idx] <= page_tag;
    end
  end

endmodule

[sv/lpr_out_stage.sv]
// result register between the lookup and the output channel
module lpr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  lpr_pkg::lpr_out_t res_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpr_pkg::lpr_out_t out_data
);

  logic              valid_r;
  logic              valid_nxt;
  lpr_pkg::lpr_out_t data_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res_data;
    end
  end

endmodule

[sv/lru_page_replacement_core.sv]
// lru page replacement core: top level with handshake stages and frame table
// Usage:
//   in channel  (in_valid/in_ready/in_data): one page reference per beat, with a
//     flag on the last reference of a run.
//   out channel (out_valid/out_ready/out_data): one result per reference, in order:
//     hit or miss, evicted page if any, running saturating fault count, run end flag.
//   cfg channel (cfg_valid/cfg_data, cfg_ready always high): number of frames in use,
//     values 0 and above FRAMES are clamped into 1..FRAMES; write only while idle.
// Timing: a reference accepted into the input register is looked up against all frame
//   tags in parallel and is then registered in the result register, where it raises
//   out_valid. One reference per cycle is sustained while out_ready stays high; the
//   limit is the combinational tag compare and rank update, which must finish before
//   the following reference is looked up.
// Reset: all frames empty, ranks and fault count zero, frames in use set to 8.
// Stall: while out_ready is low the result register holds; one more reference can
//   wait in the input register, after that in_ready drops until the result drains.
// A reference flagged last clears frames and fault count after its result is formed.
module lru_page_replacement_core #(
  parameter int FRAMES    = lpr_pkg::LPR_FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::LPR_PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lpr_pkg::lpr_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lpr_pkg::lpr_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpr_pkg::LPR_CFG_W-1:0] cfg_data
);

  logic              item_valid;
  lpr_pkg::lpr_in_t  item_data;
  logic              res_ready;
  logic              step;
  lpr_pkg::lpr_out_t result;

  // the table updates exactly when a result moves into the output register
  assign step = item_valid && res_ready;

  lpr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_take  (step)
  );

  lpr_frame_table #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_frame_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item_data),
    .result    (result)
  );

  lpr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_ready (res_ready),
    .res_data  (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.was_hit && out_data.did_evict))
    else $error("hit result also reports an eviction");

  // evicted page reads zero unless a page was replaced
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.did_evict) |-> (out_data.evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  // a resident page needs an earlier fault in the same run
  a_hit_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.was_hit) |-> (out_data.fault_total != '0))
    else $error("hit reported with zero fault count");

  // the input side is never blocked while its register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> in_ready)
    else $error("input stalled while empty");

endmodule
